// ===== sv/swrs_pkg.sv =====
// ----------------------------------------------------------------------------
// swrs_pkg: shared types and constants of the stack with reverse and search
// Holds the item layouts, the command and status codes and the control word
// that steers the row of storage cells.
// ----------------------------------------------------------------------------
package swrs_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int CMD_W     = 3;
  localparam int CNT_OUT_W = 5;
  localparam int STATUS_W  = 2;
  localparam int OP_W      = 2;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [CMD_W-1:0]         cmd_t;
  typedef logic [STATUS_W-1:0]      status_t;
  typedef logic [OP_W-1:0]          op_t;

  // Command codes.
  localparam cmd_t CMD_PUSH     = 3'd0;
  localparam cmd_t CMD_POP      = 3'd1;
  localparam cmd_t CMD_SWAP     = 3'd2;
  localparam cmd_t CMD_REVERSE  = 3'd3;
  localparam cmd_t CMD_CONTAINS = 3'd4;
  localparam cmd_t CMD_CLEAR    = 3'd5;

  // Status codes.
  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_FULL  = 2'd1;
  localparam status_t STAT_EMPTY = 2'd2;

  // Cell operations: keep, take the word from the cell above (push side),
  // or take the word from the cell below (pop side).
  localparam op_t OP_HOLD = 2'd0;
  localparam op_t OP_DOWN = 2'd1;
  localparam op_t OP_UP   = 2'd2;

  typedef struct packed {
    op_t x_op;
    op_t y_op;
  } cell_ctl_t;

  typedef struct packed {
    cmd_t  cmd;
    word_t operand_value;
  } in_item_t;

  typedef struct packed {
    word_t                top_value;
    logic                 top_valid;
    logic                 found;
    logic [CNT_OUT_W-1:0] element_count;
    status_t              status;
  } out_item_t;

endpackage

// ===== sv/swrs_stream_if.sv =====
// ----------------------------------------------------------------------------
// swrs_stream_if: valid/ready channel
// Carries one item per handshake; an item moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface swrs_stream_if #(
  parameter type item_t = logic
) ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/stack_with_reverse_and_search_unit.sv =====
// ----------------------------------------------------------------------------
// stack_with_reverse_and_search_unit: bounded LIFO stack of signed words
// Push, pop, swap of top and bottom, reverse, contains query and clear, with
// one result item per command item.
// ----------------------------------------------------------------------------
// Push, pop, clear and unused codes complete as they are accepted: the
// result is registered at the edge that accepts the item, and the next item
// may follow as soon as the output is free. Reverse and swap with two or
// more stored elements, and contains with one or more, instead run through
// the sequencer states; with fewer elements they complete like push. The
// walks there move the words between the chains, one element per cycle.
// Reset (rst_n low, synchronous) empties the stack and drops any pending
// result; the cell words are not cleared.
// ----------------------------------------------------------------------------
module stack_with_reverse_and_search_unit #(
  parameter int DEPTH = swrs_pkg::DEPTH_DEF
) (
  input logic          clk,
  input logic          rst_n,
  swrs_stream_if.sink   in_chan,
  swrs_stream_if.source out_chan
);
  import swrs_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_XFER = 3'd1;
  localparam logic [2:0] ST_SW_A = 3'd2;
  localparam logic [2:0] ST_SW_B = 3'd3;
  localparam logic [2:0] ST_SW_C = 3'd4;
  localparam logic [2:0] ST_SW_D = 3'd5;
  localparam logic [2:0] ST_SW_E = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  // The storage is a row of DEPTH cells, each holding one word of chain x and
  // one word of chain y. Cell 0 is the top of a chain. One chain is live and
  // holds the stack (top in cell 0, bottom in cell count-1); the other is the
  // spare. Popping the live chain while pushing its top onto the spare moves
  // the stack across in reverse order, one element per cycle. Reverse is one
  // such walk followed by swapping the roles of the chains; a contains query
  // walks twice, comparing the top at each step of the first walk, so that
  // the stack ends up in its original order.
  word_t x_q [DEPTH];
  word_t y_q [DEPTH];

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] steps_r, steps_nxt;
  logic             sel_r, sel_nxt;
  logic             query_r, query_nxt;
  logic             pass2_r, pass2_nxt;
  logic             found_r, found_nxt;
  logic             out_valid_r, out_valid_nxt;
  word_t            tmp_r, tmp_nxt;
  word_t            opnd_r, opnd_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic      accept;
  logic      out_free;
  logic      load_out;
  word_t     live0;
  word_t     live1;
  word_t     spare0;
  op_t       live_head_op;
  op_t       live_body_op;
  op_t       spare_head_op;
  op_t       spare_body_op;
  word_t     live_in;
  word_t     spare_in;
  word_t     x_in;
  word_t     y_in;
  cell_ctl_t head_ctl;
  cell_ctl_t body_ctl;
  word_t     res_top;
  logic      res_valid;
  logic      res_found;
  status_t   res_status;

  assign out_free      = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE) && out_free;
  assign accept        = in_chan.valid && in_chan.ready;

  assign live0  = sel_r ? y_q[0] : x_q[0];
  assign live1  = sel_r ? y_q[1] : x_q[1];
  assign spare0 = sel_r ? x_q[0] : y_q[0];

  // Sequencer and result formation.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    steps_nxt     = steps_r;
    sel_nxt       = sel_r;
    query_nxt     = query_r;
    pass2_nxt     = pass2_r;
    found_nxt     = found_r;
    tmp_nxt       = tmp_r;
    opnd_nxt      = opnd_r;
    live_head_op  = OP_HOLD;
    live_body_op  = OP_HOLD;
    spare_head_op = OP_HOLD;
    spare_body_op = OP_HOLD;
    live_in       = tmp_r;
    spare_in      = live0;
    load_out      = 1'b0;
    res_top       = (count_r != '0) ? live0 : '0;
    res_valid     = (count_r != '0);
    res_found     = 1'b0;
    res_status    = STAT_OK;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          opnd_nxt  = in_chan.data.operand_value;
          found_nxt = 1'b0;
          query_nxt = 1'b0;
          pass2_nxt = 1'b0;
          load_out  = 1'b1;
          case (in_chan.data.cmd)
            CMD_PUSH: begin
              if (count_r < CNT_W'(DEPTH)) begin
                live_head_op = OP_DOWN;
                live_body_op = OP_DOWN;
                live_in      = in_chan.data.operand_value;
                count_nxt    = count_r + CNT_W'(1);
                res_top      = in_chan.data.operand_value;
                res_valid    = 1'b1;
              end else begin
                res_status = STAT_FULL;
              end
            end
            CMD_POP: begin
              if (count_r != '0) begin
                live_head_op = OP_UP;
                live_body_op = OP_UP;
                count_nxt    = count_r - CNT_W'(1);
                res_valid    = (count_r > CNT_W'(1));
                res_top      = res_valid ? live1 : '0;
              end else begin
                res_status = STAT_EMPTY;
              end
            end
            CMD_SWAP: begin
              if (count_r >= CNT_W'(2)) begin
                state_nxt = ST_SW_A;
                load_out  = 1'b0;
              end
            end
            CMD_REVERSE: begin
              if (count_r >= CNT_W'(2)) begin
                state_nxt = ST_XFER;
                steps_nxt = count_r;
                load_out  = 1'b0;
              end
            end
            CMD_CONTAINS: begin
              if (count_r != '0) begin
                state_nxt = ST_XFER;
                steps_nxt = count_r;
                query_nxt = 1'b1;
                load_out  = 1'b0;
              end
            end
            CMD_CLEAR: begin
              count_nxt = '0;
              res_top   = '0;
              res_valid = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_XFER: begin
        // Pop the live chain onto the spare chain.
        live_head_op  = OP_UP;
        live_body_op  = OP_UP;
        spare_head_op = OP_DOWN;
        spare_body_op = OP_DOWN;
        if (query_r && !pass2_r && (live0 == opnd_r)) begin
          found_nxt = 1'b1;
        end
        if (steps_r == CNT_W'(1)) begin
          sel_nxt = ~sel_r;
          if (query_r && !pass2_r) begin
            pass2_nxt = 1'b1;
            steps_nxt = count_r;
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          steps_nxt = steps_r - CNT_W'(1);
        end
      end
      ST_SW_A: begin
        // Set the old top aside.
        tmp_nxt      = live0;
        live_head_op = OP_UP;
        live_body_op = OP_UP;
        steps_nxt    = count_r - CNT_W'(2);
        state_nxt    = (count_r > CNT_W'(2)) ? ST_SW_B : ST_SW_C;
      end
      ST_SW_B: begin
        // Park the middle elements on the spare chain.
        live_head_op  = OP_UP;
        live_body_op  = OP_UP;
        spare_head_op = OP_DOWN;
        spare_body_op = OP_DOWN;
        steps_nxt     = steps_r - CNT_W'(1);
        if (steps_r == CNT_W'(1)) begin
          state_nxt = ST_SW_C;
        end
      end
      ST_SW_C: begin
        // Only the old bottom is left: put the old top in its place.
        live_head_op = OP_DOWN;
        tmp_nxt      = live0;
        steps_nxt    = count_r - CNT_W'(2);
        state_nxt    = (count_r > CNT_W'(2)) ? ST_SW_D : ST_SW_E;
      end
      ST_SW_D: begin
        // Bring the middle elements back in their original order.
        spare_head_op = OP_UP;
        spare_body_op = OP_UP;
        live_head_op  = OP_DOWN;
        live_body_op  = OP_DOWN;
        live_in       = spare0;
        steps_nxt     = steps_r - CNT_W'(1);
        if (steps_r == CNT_W'(1)) begin
          state_nxt = ST_SW_E;
        end
      end
      ST_SW_E: begin
        // The old bottom becomes the new top.
        live_head_op = OP_DOWN;
        live_body_op = OP_DOWN;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          res_found = found_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_data_nxt  = out_data_r;
    if (load_out) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.top_value     = res_top;
      out_data_nxt.top_valid     = res_valid;
      out_data_nxt.found         = res_found;
      out_data_nxt.element_count = CNT_OUT_W'(count_nxt);
      out_data_nxt.status        = res_status;
    end
  end

  // Map the live and spare chain controls onto the physical x and y chains.
  always_comb begin
    head_ctl.x_op = sel_r ? spare_head_op : live_head_op;
    head_ctl.y_op = sel_r ? live_head_op  : spare_head_op;
    body_ctl.x_op = sel_r ? spare_body_op : live_body_op;
    body_ctl.y_op = sel_r ? live_body_op  : spare_body_op;
    x_in          = sel_r ? spare_in : live_in;
    y_in          = sel_r ? live_in  : spare_in;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    swrs_cell u_cell (
      .clk    (clk),
      .ctl    ((i == 0) ? head_ctl : body_ctl),
      .x_prev ((i == 0) ? x_in : x_q[(i == 0) ? 0 : i - 1]),
      .x_next ((i == DEPTH - 1) ? word_t'(0) : x_q[(i == DEPTH - 1) ? i : i + 1]),
      .y_prev ((i == 0) ? y_in : y_q[(i == 0) ? 0 : i - 1]),
      .y_next ((i == DEPTH - 1) ? word_t'(0) : y_q[(i == DEPTH - 1) ? i : i + 1]),
      .x_q    (x_q[i]),
      .y_q    (y_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      steps_r     <= '0;
      sel_r       <= 1'b0;
      query_r     <= 1'b0;
      pass2_r     <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      steps_r     <= steps_nxt;
      sel_r       <= sel_nxt;
      query_r     <= query_nxt;
      pass2_r     <= pass2_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tmp_r      <= tmp_nxt;
    opnd_r     <= opnd_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // The element count never passes the capacity.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("element count above capacity");

  // While a multi-cycle command runs, the element count does not move.
  a_count_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |=> $stable(count_r))
    else $error("element count changed during a multi-cycle command");

  // The chains change roles only at the end of a transfer walk.
  a_sel_flip : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_XFER) |=> $stable(sel_r))
    else $error("chain roles swapped outside a transfer walk");

endmodule

// ===== sv/swrs_cell.sv =====
// ----------------------------------------------------------------------------
// swrs_cell: one storage cell of the stack row
// Holds one word of each of the two chains and moves it to or from a neighbor.
// ----------------------------------------------------------------------------
module swrs_cell (
  input  logic                clk,
  input  swrs_pkg::cell_ctl_t ctl,
  input  swrs_pkg::word_t     x_prev,
  input  swrs_pkg::word_t     x_next,
  input  swrs_pkg::word_t     y_prev,
  input  swrs_pkg::word_t     y_next,
  output swrs_pkg::word_t     x_q,
  output swrs_pkg::word_t     y_q
);
  import swrs_pkg::*;

  word_t x_r;
  word_t x_nxt;
  word_t y_r;
  word_t y_nxt;

  function automatic word_t pick(op_t op, word_t cur, word_t prev, word_t next);
    word_t res;
    case (op)
      OP_DOWN: res = prev;
      OP_UP:   res = next;
      default: res = cur;
    endcase
    return res;
  endfunction

  always_comb begin
    x_nxt = pick(ctl.x_op, x_r, x_prev, x_next);
    y_nxt = pick(ctl.y_op, y_r, y_prev, y_next);
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
  end

  assign x_q = x_r;
  assign y_q = y_r;

endmodule
